// ===== design/exprr_pkg.sv =====
package exprr_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 1024;
  localparam int unsigned MAX_STATE_DEF   = 16;

  localparam logic [4:0]  STATE_SIZE_RST  = 5'd4;
  localparam logic [10:0] BUFFER_SIZE_RST = 11'd1024;

  localparam logic REG_STATE_SIZE  = 1'b0;
  localparam logic REG_BUFFER_SIZE = 1'b1;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [4:0] DIV_LAST = 5'd30;

  typedef struct packed {
    logic        func;
    logic [31:0] elem;
    logic [15:0] action;
    logic [31:0] reward;
    logic        episode_end;
    logic [30:0] rand_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] state_elem;
    logic [31:0] next_elem;
    logic [15:0] action_out;
    logic [31:0] reward_out;
    logic        end_out;
    logic        final_elem;
    logic        empty_flag;
  } out_item_t;

  typedef struct packed {
    logic [15:0] action;
    logic [31:0] reward;
    logic        episode_end;
  } slot_scalars_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CP_RD,
    ST_CP_WR,
    ST_DIV,
    ST_NXT,
    ST_RDC,
    ST_RDN,
    ST_EMIT,
    ST_EMPTY
  } seq_state_e;

endpackage

// ===== design/exprr_ram.sv =====
module exprr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/experience_replay_ring.sv =====
// Add: one element per cycle while idle; the final element starts a copy of the pending
//   elements into the ring, read then written element by element, during which no item is taken.
// Sample: a 31-step restoring remainder unit finds the slot; each result then takes two
//   state reads (current, then next slot) and one output load, and waits while the output stalls.
// Empty sample: its single result is loaded in the empty state once the output is free.
// Reset clears pointers and counts at once; the stores hold no reset value.
module experience_replay_ring #(
  parameter int unsigned MAX_ENTRIES = exprr_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned MAX_STATE   = exprr_pkg::MAX_STATE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  exprr_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output exprr_pkg::out_item_t out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import exprr_pkg::*;

  localparam int unsigned PW  = $clog2(MAX_ENTRIES);
  localparam int unsigned FW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KW  = (MAX_STATE > 1) ? $clog2(MAX_STATE) : 1;
  localparam int unsigned SW  = $clog2(MAX_STATE + 1);
  localparam int unsigned SCW = $bits(slot_scalars_t);

  seq_state_e    state_q, state_d;
  logic [4:0]    state_size_q, state_size_d;
  logic [10:0]   buffer_size_q, buffer_size_d;
  logic [PW-1:0] write_ptr_q, write_ptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [KW-1:0] ec_q, ec_d;
  logic [KW-1:0] kcnt_q, kcnt_d;
  logic [4:0]    dcnt_q, dcnt_d;
  logic [30:0]   dvd_q, dvd_d;
  logic [FW-1:0] rem_q, rem_d;
  logic [PW-1:0] idx_q, idx_d;
  logic [PW-1:0] nxt_q, nxt_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   cur_q, cur_d;
  out_item_t     out_q, out_d;

  logic [SW-1:0] ss_eff;
  logic [FW-1:0] bs_eff;
  logic          cfg_wr;
  logic          in_acc;
  logic          out_free;
  logic          last_k;
  logic [FW:0]   div_t;
  logic [FW:0]   div_diff;
  logic [FW-1:0] wp_inc;
  logic [FW-1:0] rem_inc;
  logic          masked;

  logic                 pend_we;
  logic [31:0]          pend_rdata;
  logic                 st_we;
  logic [PW+KW-1:0]     st_waddr;
  logic [PW+KW-1:0]     st_raddr;
  logic [31:0]          st_rdata;
  logic                 sc_we;
  slot_scalars_t        sc_wdata;
  slot_scalars_t        sc_rdata;
  logic [SCW-1:0]       sc_rbits;

  always_comb begin
    if (state_size_q == 5'd0) begin
      ss_eff = SW'(1);
    end else if (32'(state_size_q) > 32'(MAX_STATE)) begin
      ss_eff = SW'(MAX_STATE);
    end else begin
      ss_eff = SW'(state_size_q);
    end
    if (buffer_size_q == 11'd0) begin
      bs_eff = FW'(1);
    end else if (32'(buffer_size_q) > 32'(MAX_ENTRIES)) begin
      bs_eff = FW'(MAX_ENTRIES);
    end else begin
      bs_eff = FW'(buffer_size_q);
    end
  end

  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_BUFFER_SIZE) ? 32'(buffer_size_q) : 32'(state_size_q);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_k     = (SW'(kcnt_q) + SW'(1)) == ss_eff;
  assign div_t      = {rem_q, dvd_q[30]};
  assign div_diff   = div_t - {1'b0, fill_q};
  assign wp_inc     = FW'(write_ptr_q) + FW'(1);
  assign rem_inc    = rem_q + FW'(1);
  assign masked     = sc_rdata.episode_end || (nxt_q == write_ptr_q);
  assign sc_rdata   = slot_scalars_t'(sc_rbits);

  assign sc_wdata.action      = in_item_i.action;
  assign sc_wdata.reward      = in_item_i.reward;
  assign sc_wdata.episode_end = in_item_i.episode_end;

  always_comb begin
    state_d       = state_q;
    state_size_d  = state_size_q;
    buffer_size_d = buffer_size_q;
    write_ptr_d   = write_ptr_q;
    fill_d        = fill_q;
    ec_d          = ec_q;
    kcnt_d        = kcnt_q;
    dcnt_d        = dcnt_q;
    dvd_d         = dvd_q;
    rem_d         = rem_q;
    idx_d         = idx_q;
    nxt_d         = nxt_q;
    cur_d         = cur_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && out_stall_i;
    pend_we       = 1'b0;
    st_we         = 1'b0;
    sc_we         = 1'b0;
    st_waddr      = {write_ptr_q, kcnt_q};
    st_raddr      = {nxt_q, kcnt_q};

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item_i.func == FUNC_ADD) begin
            pend_we = 1'b1;
            if ((SW'(ec_q) + SW'(1)) >= ss_eff) begin
              sc_we   = 1'b1;
              ec_d    = '0;
              kcnt_d  = '0;
              state_d = ST_CP_RD;
            end else begin
              ec_d = ec_q + KW'(1);
            end
          end else if (fill_q == '0) begin
            state_d = ST_EMPTY;
          end else begin
            dvd_d   = in_item_i.rand_value;
            rem_d   = '0;
            dcnt_d  = '0;
            kcnt_d  = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_CP_RD: begin
        state_d = ST_CP_WR;
      end
      ST_CP_WR: begin
        st_we = 1'b1;
        if (last_k) begin
          kcnt_d      = '0;
          write_ptr_d = (wp_inc == bs_eff) ? '0 : PW'(wp_inc);
          if (fill_q < bs_eff) begin
            fill_d = fill_q + FW'(1);
          end
          state_d = ST_IDLE;
        end else begin
          kcnt_d  = kcnt_q + KW'(1);
          state_d = ST_CP_RD;
        end
      end
      ST_DIV: begin
        dvd_d  = {dvd_q[29:0], 1'b0};
        rem_d  = div_diff[FW] ? FW'(div_t) : FW'(div_diff);
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == DIV_LAST) begin
          state_d = ST_NXT;
        end
      end
      ST_NXT: begin
        idx_d   = PW'(rem_q);
        nxt_d   = (rem_inc == bs_eff) ? '0 : PW'(rem_inc);
        state_d = ST_RDC;
      end
      ST_RDC: begin
        st_raddr = {idx_q, kcnt_q};
        state_d  = ST_RDN;
      end
      ST_RDN: begin
        cur_d   = st_rdata;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.state_elem = cur_q;
          out_d.next_elem  = masked ? 32'd0 : st_rdata;
          out_d.action_out = sc_rdata.action;
          out_d.reward_out = sc_rdata.reward;
          out_d.end_out    = sc_rdata.episode_end;
          out_d.final_elem = last_k;
          out_d.empty_flag = 1'b0;
          if (last_k) begin
            kcnt_d  = '0;
            state_d = ST_IDLE;
          end else begin
            kcnt_d  = kcnt_q + KW'(1);
            state_d = ST_RDC;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.state_elem = '0;
          out_d.next_elem  = '0;
          out_d.action_out = '0;
          out_d.reward_out = '0;
          out_d.end_out    = 1'b0;
          out_d.final_elem = 1'b1;
          out_d.empty_flag = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // any register write empties the ring
    if (cfg_wr) begin
      if (paddr[2] == REG_STATE_SIZE) begin
        state_size_d = pwdata[4:0];
      end else begin
        buffer_size_d = pwdata[10:0];
      end
      write_ptr_d = '0;
      fill_d      = '0;
      ec_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      state_size_q  <= STATE_SIZE_RST;
      buffer_size_q <= BUFFER_SIZE_RST;
      write_ptr_q   <= '0;
      fill_q        <= '0;
      ec_q          <= '0;
      kcnt_q        <= '0;
      dcnt_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      state_size_q  <= state_size_d;
      buffer_size_q <= buffer_size_d;
      write_ptr_q   <= write_ptr_d;
      fill_q        <= fill_d;
      ec_q          <= ec_d;
      kcnt_q        <= kcnt_d;
      dcnt_q        <= dcnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    idx_q <= idx_d;
    nxt_q <= nxt_d;
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  exprr_ram #(
    .WIDTH (32),
    .DEPTH (2 ** KW)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (ec_q),
    .wdata_i (in_item_i.elem),
    .raddr_i (kcnt_q),
    .rdata_o (pend_rdata)
  );

  exprr_ram #(
    .WIDTH (32),
    .DEPTH (MAX_ENTRIES * (2 ** KW))
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (pend_rdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  exprr_ram #(
    .WIDTH (SCW),
    .DEPTH (MAX_ENTRIES)
  ) u_scal_ram (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (write_ptr_q),
    .wdata_i (SCW'(sc_wdata)),
    .raddr_i (idx_q),
    .rdata_o (sc_rbits)
  );

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= bs_eff)
    else $error("fill count above ring size");

  a_wptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FW'(write_ptr_q) < bs_eff)
    else $error("write pointer outside ring");

  a_empty_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.empty_flag) |-> out_item_o.final_elem)
    else $error("empty result not marked final");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_item_i.func == FUNC_SAMPLE)) |=> in_stall_o)
    else $error("sample item did not hold off the input");

  a_copy_wptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CP_WR) |=> ((state_q == ST_CP_RD) || (state_q == ST_IDLE)))
    else $error("commit copy left its sequence");

endmodule
